// File: design/acr_pkg.sv
// Shared types, constants and helpers for the auto-ranging current sequencer.
`default_nettype none

package acr_pkg;

    localparam int SAMPLE_W   = 15;
    localparam int CUR_W      = 16;
    localparam int GAIN_W     = 2;
    localparam int PIN_W      = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam int LEN_W      = 5;
    localparam int DEAD_W     = 13;

    localparam int MAX_LEN_S_DEF = 20;

    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEN    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEAD   = 2'd2;

    localparam logic [LEN_W-1:0]  LEN_RESET  = 5'd1;
    localparam logic [DEAD_W-1:0] DEAD_RESET = 13'd20;

    localparam int MS_PER_S     = 1000;
    localparam int TICK_MS      = 10;
    localparam int ZERO_END_OFS = 5;
    localparam int DEAD_MIN     = 20;

    localparam logic [SAMPLE_W-1:0] MAX_HIGH_LIM = 15'd16000;
    localparam logic [SAMPLE_W-1:0] MIN_LOW_LIM  = 15'd380;
    localparam logic [SAMPLE_W-1:0] MIN_INIT     = 15'd17000;
    localparam logic [CUR_W-1:0]    CUR_HIGH_LIM = 16'd8000;
    localparam logic [CUR_W-1:0]    CUR_LOW_LIM  = 16'd320;

    localparam logic [PIN_W-1:0] PIN_MASK  = 6'h38;
    localparam logic [PIN_W-1:0] PIN_RELAY = 6'h08;
    localparam logic [PIN_W-1:0] GAIN_PIN1 = 6'h20;
    localparam logic [PIN_W-1:0] GAIN_PIN2 = 6'h10;
    localparam logic [PIN_W-1:0] GAIN_PIN3 = 6'h30;

    localparam logic [GAIN_W-1:0] GAIN_0 = 2'd0;
    localparam logic [GAIN_W-1:0] GAIN_1 = 2'd1;
    localparam logic [GAIN_W-1:0] GAIN_2 = 2'd2;
    localparam logic [GAIN_W-1:0] GAIN_3 = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_STEP,
        S_DIV_SIG,
        S_DIV_ZERO,
        S_OUT
    } seq_state_t;

    function automatic logic [PIN_W-1:0] gain_pins(input logic [GAIN_W-1:0] g);
        logic [PIN_W-1:0] m;
        case (g)
            GAIN_1:  m = GAIN_PIN1;
            GAIN_2:  m = GAIN_PIN2;
            GAIN_3:  m = GAIN_PIN3;
            default: m = '0;
        endcase
        return m & PIN_MASK;
    endfunction

endpackage

`default_nettype wire

// File: design/autoranging_current_measure_sequencer.sv
// Top level: tick sequencer, phase accumulators, gain ranging and result register.
//
// One item is one 10 ms tick with its converter sample; every tick yields one result item.
// A tick passes from acceptance through S_STEP and S_OUT to the output register; the tick
// closing a measurement cycle with samples in both phases also passes S_DIV_SIG and
// S_DIV_ZERO, where the one bit-serial divider forms both phase averages, one quotient bit
// a cycle. The block takes no new tick until the current one has been placed in the output
// register; a waiting result holds the next tick in S_OUT but does not hold off its acceptance.
// Configuration is taken at any time and the length and dead time are latched at each cycle start.
`default_nettype none

module autoranging_current_measure_sequencer
    import acr_pkg::*;
#(
    parameter int MAX_LEN_S = MAX_LEN_S_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [SAMPLE_W-1:0]   adc_sample,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [PIN_W-1:0]           pin_code,
    output logic                       pin_write,
    output logic                       ready_res,
    output logic signed [CUR_W-1:0]    current_value,
    output logic [SAMPLE_W-1:0]        signal_average,
    output logic [SAMPLE_W-1:0]        zero_average,
    output logic [GAIN_W-1:0]          gain_code,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int TIME_W = $clog2(MAX_LEN_S * MS_PER_S);
    localparam int CALC_W = (TIME_W + 1 > DEAD_W) ? TIME_W + 1 : DEAD_W;
    localparam int CNT_W  = $clog2(MAX_LEN_S * 100 + 1);
    localparam int SUM_W  = SAMPLE_W + CNT_W;

    seq_state_t state_reg, state_next;

    logic               en_reg, en_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic [DEAD_W-1:0]  dead_reg, dead_next;

    logic [SAMPLE_W-1:0] sample_reg;

    logic [TIME_W-1:0] elapsed_reg, elapsed_next;
    logic [TIME_W-1:0] zero_dead_reg, zero_dead_next;
    logic [TIME_W-1:0] zero_end_reg, zero_end_next;
    logic [TIME_W-1:0] sig_dead_reg, sig_dead_next;
    logic [TIME_W-1:0] sig_end_reg, sig_end_next;
    logic [GAIN_W-1:0] gain_reg, gain_next;

    logic [SUM_W-1:0]    zero_sum_reg, zero_sum_next, sig_sum_reg, sig_sum_next;
    logic [CNT_W-1:0]    zero_cnt_reg, zero_cnt_next, sig_cnt_reg, sig_cnt_next;
    logic [SAMPLE_W-1:0] zero_max_reg, zero_max_next, zero_min_reg, zero_min_next;
    logic [SAMPLE_W-1:0] sig_max_reg, sig_max_next, sig_min_reg, sig_min_next;

    logic signed [CUR_W-1:0] last_cur_reg, last_cur_next;
    logic [SAMPLE_W-1:0]     last_sig_reg, last_sig_next, last_zero_reg, last_zero_next;

    logic [PIN_W-1:0] res_pin_reg, res_pin_next;
    logic             res_wr_reg, res_wr_next, res_rdy_reg, res_rdy_next;

    logic                    out_valid_reg, out_valid_next;
    logic [PIN_W-1:0]        out_pin_reg;
    logic                    out_wr_reg, out_rdy_reg;
    logic signed [CUR_W-1:0] out_cur_reg;
    logic [SAMPLE_W-1:0]     out_sig_reg, out_zero_reg;
    logic [GAIN_W-1:0]       out_gain_reg;

    logic              div_start, div_done, out_load;
    logic [SUM_W-1:0]  div_dividend, div_quotient;
    logic [CNT_W-1:0]  div_divisor;

    logic [TIME_W:0] el_inc;
    logic            in_zero, in_sig, tick_finish, have_samples;
    logic [CUR_W-1:0] cur_mag;
    logic            range_high, range_low;
    logic [GAIN_W-1:0] gain_ranged;

    logic [CALC_W-1:0] len_c, lms_c, half_c, dt_c;

    // phase boundaries from the current configuration, latched at cycle start
    always_comb
    begin
        len_c = CALC_W'(len_reg);
        if (len_c == '0)
            len_c = CALC_W'(1);
        if (len_c > CALC_W'(MAX_LEN_S))
            len_c = CALC_W'(MAX_LEN_S);
        lms_c  = len_c * CALC_W'(MS_PER_S);
        half_c = lms_c >> 1;
        dt_c   = CALC_W'(dead_reg);
        if (dt_c > (lms_c >> 2))
            dt_c = lms_c >> 2;
        if (dt_c < CALC_W'(DEAD_MIN))
            dt_c = CALC_W'(DEAD_MIN);
    end

    // gain ranging on the previous cycle's extremes and result
    always_comb
    begin
        cur_mag    = last_cur_reg[CUR_W-1] ? CUR_W'(-last_cur_reg) : CUR_W'(last_cur_reg);
        range_high = (sig_max_reg > MAX_HIGH_LIM) || (zero_max_reg > MAX_HIGH_LIM)
                     || (cur_mag > CUR_HIGH_LIM);
        range_low  = (sig_min_reg < MIN_LOW_LIM) || (zero_min_reg < MIN_LOW_LIM)
                     || (cur_mag < CUR_LOW_LIM);
        gain_ranged = gain_reg;
        case (gain_reg)
            GAIN_3:
            begin
                if (range_high)
                    gain_ranged = GAIN_2;
            end
            GAIN_2:
            begin
                if (range_high)
                    gain_ranged = GAIN_1;
                else if (range_low)
                    gain_ranged = GAIN_3;
            end
            GAIN_1:
            begin
                if (range_high)
                    gain_ranged = GAIN_0;
                else if (range_low)
                    gain_ranged = GAIN_2;
            end
            default:
            begin
                if (range_low)
                    gain_ranged = GAIN_1;
            end
        endcase
    end

    assign el_inc       = {1'b0, elapsed_reg} + (TIME_W + 1)'(TICK_MS);
    assign in_zero      = el_inc < {1'b0, zero_end_reg};
    assign in_sig       = el_inc < {1'b0, sig_end_reg};
    assign tick_finish  = en_reg && (elapsed_reg != '0) && !in_zero && !in_sig;
    assign have_samples = (sig_cnt_reg != '0) && (zero_cnt_reg != '0);

    // sequencer: next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    state_next = S_STEP;
            end
            S_STEP:
            begin
                if (tick_finish && have_samples)
                    state_next = S_DIV_SIG;
                else
                    state_next = S_OUT;
            end
            S_DIV_SIG:
            begin
                if (div_done)
                    state_next = S_DIV_ZERO;
            end
            S_DIV_ZERO:
            begin
                if (div_done)
                    state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // sequencer: control outputs
    always_comb
    begin
        in_ready  = 1'b0;
        div_start = 1'b0;
        out_load  = 1'b0;
        case (state_reg)
            S_IDLE:     in_ready  = 1'b1;
            S_STEP:     div_start = tick_finish && have_samples;
            S_DIV_SIG:  div_start = div_done;
            S_OUT:      out_load  = !out_valid_reg || out_ready;
            default:    ;
        endcase
    end

    assign div_dividend = (state_reg == S_DIV_SIG) ? zero_sum_reg : sig_sum_reg;
    assign div_divisor  = (state_reg == S_DIV_SIG) ? zero_cnt_reg : sig_cnt_reg;

    acr_div #(
        .DIVIDEND_W (SUM_W),
        .DIVISOR_W  (CNT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // configuration writes
    always_comb
    begin
        en_next   = en_reg;
        len_next  = len_reg;
        dead_next = dead_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_ENABLE: en_next   = cfg_data[0];
                CFG_LEN:    len_next  = cfg_data[LEN_W-1:0];
                CFG_DEAD:   dead_next = cfg_data[DEAD_W-1:0];
                default:    ;
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    // tick datapath
    always_comb
    begin
        elapsed_next   = elapsed_reg;
        zero_dead_next = zero_dead_reg;
        zero_end_next  = zero_end_reg;
        sig_dead_next  = sig_dead_reg;
        sig_end_next   = sig_end_reg;
        gain_next      = gain_reg;
        zero_sum_next  = zero_sum_reg;
        zero_cnt_next  = zero_cnt_reg;
        zero_max_next  = zero_max_reg;
        zero_min_next  = zero_min_reg;
        sig_sum_next   = sig_sum_reg;
        sig_cnt_next   = sig_cnt_reg;
        sig_max_next   = sig_max_reg;
        sig_min_next   = sig_min_reg;
        last_cur_next  = last_cur_reg;
        last_sig_next  = last_sig_reg;
        last_zero_next = last_zero_reg;
        res_pin_next   = res_pin_reg;
        res_wr_next    = res_wr_reg;
        res_rdy_next   = res_rdy_reg;

        if (state_reg == S_STEP)
        begin
            res_pin_next = '0;
            res_wr_next  = 1'b0;
            res_rdy_next = 1'b0;
            if (en_reg)
            begin
                if (elapsed_reg == '0)
                begin
                    gain_next      = gain_ranged;
                    elapsed_next   = TIME_W'(1);
                    zero_dead_next = TIME_W'(dt_c);
                    zero_end_next  = TIME_W'(half_c - CALC_W'(ZERO_END_OFS));
                    sig_dead_next  = TIME_W'(dt_c + half_c - CALC_W'(TICK_MS));
                    sig_end_next   = TIME_W'(lms_c - CALC_W'(TICK_MS));
                    zero_sum_next  = '0;
                    zero_cnt_next  = '0;
                    zero_max_next  = '0;
                    zero_min_next  = MIN_INIT;
                    sig_sum_next   = '0;
                    sig_cnt_next   = '0;
                    sig_max_next   = '0;
                    sig_min_next   = MIN_INIT;
                end
                else if (in_zero)
                begin
                    elapsed_next = el_inc[TIME_W-1:0];
                    res_pin_next = gain_pins(gain_reg);
                    res_wr_next  = 1'b1;
                    if (el_inc >= {1'b0, zero_dead_reg})
                    begin
                        zero_sum_next = zero_sum_reg + SUM_W'(sample_reg);
                        zero_cnt_next = zero_cnt_reg + CNT_W'(1);
                        if (sample_reg > zero_max_reg)
                            zero_max_next = sample_reg;
                        if (sample_reg < zero_min_reg)
                            zero_min_next = sample_reg;
                    end
                end
                else if (in_sig)
                begin
                    elapsed_next = el_inc[TIME_W-1:0];
                    res_pin_next = (gain_pins(gain_reg) | PIN_RELAY) & PIN_MASK;
                    res_wr_next  = 1'b1;
                    if (el_inc >= {1'b0, sig_dead_reg})
                    begin
                        sig_sum_next = sig_sum_reg + SUM_W'(sample_reg);
                        sig_cnt_next = sig_cnt_reg + CNT_W'(1);
                        if (sample_reg > sig_max_reg)
                            sig_max_next = sample_reg;
                        if (sample_reg < sig_min_reg)
                            sig_min_next = sample_reg;
                    end
                end
                else
                begin
                    elapsed_next = '0;
                    res_pin_next = gain_pins(gain_reg);
                    res_wr_next  = 1'b1;
                    res_rdy_next = 1'b1;
                    // a phase without samples gives an all-zero result
                    if (!have_samples)
                    begin
                        last_cur_next  = '0;
                        last_sig_next  = '0;
                        last_zero_next = '0;
                    end
                end
            end
        end
        else if (state_reg == S_DIV_SIG && div_done)
        begin
            last_sig_next = div_quotient[SAMPLE_W-1:0];
        end
        else if (state_reg == S_DIV_ZERO && div_done)
        begin
            last_zero_next = div_quotient[SAMPLE_W-1:0];
            last_cur_next  = signed'(CUR_W'({1'b0, last_sig_reg}))
                             - signed'(CUR_W'({1'b0, div_quotient[SAMPLE_W-1:0]}));
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            en_reg        <= 1'b0;
            len_reg       <= LEN_RESET;
            dead_reg      <= DEAD_RESET;
            elapsed_reg   <= '0;
            zero_dead_reg <= '0;
            zero_end_reg  <= '0;
            sig_dead_reg  <= '0;
            sig_end_reg   <= '0;
            gain_reg      <= GAIN_0;
            zero_sum_reg  <= '0;
            zero_cnt_reg  <= '0;
            zero_max_reg  <= '0;
            zero_min_reg  <= '0;
            sig_sum_reg   <= '0;
            sig_cnt_reg   <= '0;
            sig_max_reg   <= '0;
            sig_min_reg   <= '0;
            last_cur_reg  <= '0;
            last_sig_reg  <= '0;
            last_zero_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            en_reg        <= en_next;
            len_reg       <= len_next;
            dead_reg      <= dead_next;
            elapsed_reg   <= elapsed_next;
            zero_dead_reg <= zero_dead_next;
            zero_end_reg  <= zero_end_next;
            sig_dead_reg  <= sig_dead_next;
            sig_end_reg   <= sig_end_next;
            gain_reg      <= gain_next;
            zero_sum_reg  <= zero_sum_next;
            zero_cnt_reg  <= zero_cnt_next;
            zero_max_reg  <= zero_max_next;
            zero_min_reg  <= zero_min_next;
            sig_sum_reg   <= sig_sum_next;
            sig_cnt_reg   <= sig_cnt_next;
            sig_max_reg   <= sig_max_next;
            sig_min_reg   <= sig_min_next;
            last_cur_reg  <= last_cur_next;
            last_sig_reg  <= last_sig_next;
            last_zero_reg <= last_zero_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            sample_reg <= adc_sample;
        res_pin_reg <= res_pin_next;
        res_wr_reg  <= res_wr_next;
        res_rdy_reg <= res_rdy_next;
        if (out_load)
        begin
            out_pin_reg  <= res_pin_reg;
            out_wr_reg   <= res_wr_reg;
            out_rdy_reg  <= res_rdy_reg;
            out_cur_reg  <= last_cur_reg;
            out_sig_reg  <= last_sig_reg;
            out_zero_reg <= last_zero_reg;
            out_gain_reg <= gain_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign pin_code       = out_pin_reg;
    assign pin_write      = out_wr_reg;
    assign ready_res      = out_rdy_reg;
    assign current_value  = out_cur_reg;
    assign signal_average = out_sig_reg;
    assign zero_average   = out_zero_reg;
    assign gain_code      = out_gain_reg;

    a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIV_SIG || state_reg == S_DIV_ZERO))
        else $error("divider finished outside a division state");

    a_elapsed_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (elapsed_reg != '0) |-> ({1'b0, elapsed_reg} < {1'b0, sig_end_reg}
                                 + (TIME_W + 1)'(TICK_MS)))
        else $error("elapsed time ran past the end of the cycle");

    a_zero_extremes: assert property (@(posedge clk) disable iff (!rst_n)
        (zero_cnt_reg != '0) |-> (zero_min_reg <= zero_max_reg))
        else $error("zero phase min above max with samples taken");

    a_ready_writes: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && ready_res) |-> pin_write)
        else $error("result flagged ready without a pin write");

endmodule

`default_nettype wire

// File: design/acr_div.sv
// Bit-serial restoring divider shared by both phase averages.
`default_nettype none

module acr_div
    import acr_pkg::*;
#(
    parameter int DIVIDEND_W = 26,
    parameter int DIVISOR_W  = 11
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic [DIVIDEND_W-1:0] dividend,
    input  wire logic [DIVISOR_W-1:0]  divisor,
    output logic                       done,
    output logic [DIVIDEND_W-1:0]      quotient
);

    localparam int STEP_W = (DIVIDEND_W > 1) ? $clog2(DIVIDEND_W) : 1;

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [STEP_W-1:0]     step_reg, step_next;
    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVISOR_W-1:0]  dsr_reg, dsr_next;
    logic [DIVISOR_W:0]    trial;

    always_comb
    begin
        trial     = {rem_reg, quo_reg[DIVIDEND_W-1]};
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = STEP_W'(DIVIDEND_W - 1);
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dsr_reg})
            begin
                rem_next = DIVISOR_W'(trial - {1'b0, dsr_reg});
                quo_next = {quo_reg[DIVIDEND_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DIVISOR_W-1:0];
                quo_next = {quo_reg[DIVIDEND_W-2:0], 1'b0};
            end
            if (step_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                step_next = step_reg - STEP_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire
